[hdl/dpmn_pkg.sv]
package dpmn_pkg;

  localparam int BPC_W = 5;
  localparam int CLK_W = 20;
  localparam int CODE_W = 8;
  localparam int LANE_W = 4;
  localparam int DM_W = 24;
  localparam int DN_W = 24;
  localparam int LM_W = 24;
  localparam int LN_W = 21;
  localparam int ST_W = 2;

  localparam int SYM_W = 30;
  localparam int PROD_W = 27;
  localparam int DMRAW_W = 37;
  localparam int LMRAW_W = 30;

  localparam int DIVW = 60;
  localparam int DSRW = 36;
  localparam int QW = 32;
  localparam int CNTW = $clog2(DIVW);

  localparam int DATA_SHIFT = 23;
  localparam int LINK_SHIFT = 20;

  localparam logic [DN_W-1:0] DN_CAP = 24'h800000;
  localparam logic [DN_W-1:0] LN_CAP = 24'h100000;
  localparam logic [QW-1:0] M_N_LIMIT = QW'((1 << 24) - 1);

  localparam logic [CODE_W-1:0] RATE_162 = 8'h06;
  localparam logic [CODE_W-1:0] RATE_270 = 8'h0A;
  localparam logic [CODE_W-1:0] RATE_540 = 8'h14;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_RATE = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_LANES = 2'd2;

  function automatic logic rate_ok(input logic [CODE_W-1:0] code);
    return (code == RATE_162) || (code == RATE_270) || (code == RATE_540);
  endfunction

  function automatic logic [SYM_W-1:0] sym_rate(input logic [CODE_W-1:0] code);
    logic [SYM_W-1:0] r;
    r = '0;
    if (code == RATE_162) begin
      r = SYM_W'(162000000);
    end else if (code == RATE_270) begin
      r = SYM_W'(270000000);
    end else if (code == RATE_540) begin
      r = SYM_W'(540000000);
    end
    return r;
  endfunction

endpackage

[hdl/dpmn_div.sv]
module dpmn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dpmn_pkg::DIVW-1:0] dividend,
  input  logic [dpmn_pkg::DSRW-1:0] divisor,
  output logic                      done,
  output logic [dpmn_pkg::QW-1:0]   quotient
);
  import dpmn_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNTW-1:0]   cnt_r;
  logic [DIVW-1:0]   dvd_r;
  logic [DSRW-1:0]   dsr_r;
  logic [DSRW-1:0]   rem_r;
  logic [QW-1:0]     quo_r;
  logic [DSRW:0]     rem_sh;
  logic [DSRW:0]     diff;
  logic              ge;

  assign rem_sh = {rem_r, dvd_r[DIVW-1]};
  assign ge = rem_sh >= {1'b0, dsr_r};
  assign diff = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(DIVW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIVW-2:0], 1'b0};
      rem_r <= ge ? diff[DSRW-1:0] : rem_sh[DSRW-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

[hdl/dp_link_m_n_calculator.sv]
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_ready    bpc, pixel clock, rate code, lanes
// out      output     out_valid / out_ready  data M/N, link M/N, status
//
// A valid request passes the prepare and multiply states, a data pass and a link pass of the
// shared restoring divider, and a halving of the data pair per normalize step (at most six;
// link M always fits) before it reaches the output register, once that register can take it.
// A request with a bad rate code or zero lanes goes straight to the done state instead.
// Reset is synchronous and active low and clears the sequencer and output valid.
// A finished word waits in the output register; a new request is taken meanwhile,
// and its result waits in the sequencer until the output register is free.
module dp_link_m_n_calculator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dpmn_pkg::BPC_W-1:0]  in_bits_per_component,
  input  logic [dpmn_pkg::CLK_W-1:0]  in_pixel_clock_khz,
  input  logic [dpmn_pkg::CODE_W-1:0] in_link_rate_code,
  input  logic [dpmn_pkg::LANE_W-1:0] in_lane_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dpmn_pkg::DM_W-1:0]   out_data_m,
  output logic [dpmn_pkg::DN_W-1:0]   out_data_n,
  output logic [dpmn_pkg::LM_W-1:0]   out_link_m,
  output logic [dpmn_pkg::LN_W-1:0]   out_link_n,
  output logic [dpmn_pkg::ST_W-1:0]   out_status
);
  import dpmn_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_DMUL   = 4'd2;
  localparam logic [3:0] S_DSTART = 4'd3;
  localparam logic [3:0] S_DWAIT  = 4'd4;
  localparam logic [3:0] S_DNORM  = 4'd5;
  localparam logic [3:0] S_LSTART = 4'd6;
  localparam logic [3:0] S_LWAIT  = 4'd7;
  localparam logic [3:0] S_LNORM  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept, load_out;

  logic [BPC_W-1:0]    bpc_r;
  logic [CLK_W-1:0]    clk_r;
  logic [LANE_W-1:0]   lanes_r;
  logic [SYM_W-1:0]    sym_r;
  logic [6:0]          bpc3;
  logic [PROD_W-1:0]   prod_r;
  logic [DMRAW_W-1:0]  dm_r;
  logic [LMRAW_W-1:0]  lm_r;
  logic [DSRW-1:0]     dn_r;
  logic [QW-1:0]       q_r;
  logic [DN_W-1:0]     n_r;
  logic [DM_W-1:0]     res_dm_r;
  logic [DN_W-1:0]     res_dn_r;
  logic [LM_W-1:0]     res_lm_r;
  logic [LN_W-1:0]     res_ln_r;
  logic [ST_W-1:0]     res_st_r;
  logic [DM_W-1:0]     out_dm_r;
  logic [DN_W-1:0]     out_dn_r;
  logic [LM_W-1:0]     out_lm_r;
  logic [LN_W-1:0]     out_ln_r;
  logic [ST_W-1:0]     out_st_r;

  logic                div_start;
  logic                div_done;
  logic [DIVW-1:0]     div_dividend;
  logic [DSRW-1:0]     div_divisor;
  logic [QW-1:0]       div_quotient;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign bpc3 = 7'(bpc_r) * 7'd3;

  assign div_start = (state_r == S_DSTART) || (state_r == S_LSTART);
  assign div_dividend = (state_r == S_LSTART) ? DIVW'({lm_r, {LINK_SHIFT{1'b0}}})
                                              : DIVW'({dm_r, {DATA_SHIFT{1'b0}}});
  assign div_divisor = (state_r == S_LSTART) ? DSRW'(sym_r) : dn_r;

  dpmn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!rate_ok(in_link_rate_code) || (in_lane_count == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP:   state_nxt = S_DMUL;
      S_DMUL:   state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_nxt = S_DNORM;
        end
      end
      S_DNORM: begin
        if (q_r <= M_N_LIMIT) begin
          state_nxt = S_LSTART;
        end
      end
      S_LSTART: state_nxt = S_LWAIT;
      S_LWAIT: begin
        if (div_done) begin
          state_nxt = S_LNORM;
        end
      end
      S_LNORM: begin
        if (q_r <= M_N_LIMIT) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          bpc_r <= in_bits_per_component;
          clk_r <= in_pixel_clock_khz;
          lanes_r <= in_lane_count;
          sym_r <= sym_rate(in_link_rate_code);
          res_dm_r <= '0;
          res_dn_r <= '0;
          res_lm_r <= '0;
          res_ln_r <= '0;
          if (!rate_ok(in_link_rate_code)) begin
            res_st_r <= ST_BAD_RATE;
          end else if (in_lane_count == '0) begin
            res_st_r <= ST_NO_LANES;
          end else begin
            res_st_r <= ST_OK;
          end
        end
      end
      S_PREP: begin
        prod_r <= PROD_W'(PROD_W'(clk_r) * PROD_W'(bpc3));
        lm_r <= LMRAW_W'(LMRAW_W'(clk_r) * LMRAW_W'(1000));
        dn_r <= DSRW'({34'(34'(sym_r) * 34'(lanes_r)), 3'b000});
      end
      S_DMUL: begin
        dm_r <= DMRAW_W'(DMRAW_W'(prod_r) * DMRAW_W'(1000));
      end
      S_DWAIT: begin
        if (div_done) begin
          q_r <= div_quotient;
          n_r <= DN_CAP;
        end
      end
      S_DNORM: begin
        if (q_r > M_N_LIMIT) begin
          q_r <= q_r >> 1;
          n_r <= n_r >> 1;
        end else begin
          res_dm_r <= q_r[DM_W-1:0];
          res_dn_r <= n_r;
        end
      end
      S_LWAIT: begin
        if (div_done) begin
          q_r <= div_quotient;
          n_r <= LN_CAP;
        end
      end
      S_LNORM: begin
        if (q_r > M_N_LIMIT) begin
          q_r <= q_r >> 1;
          n_r <= n_r >> 1;
        end else begin
          res_lm_r <= q_r[LM_W-1:0];
          res_ln_r <= n_r[LN_W-1:0];
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_dm_r <= res_dm_r;
          out_dn_r <= res_dn_r;
          out_lm_r <= res_lm_r;
          out_ln_r <= res_ln_r;
          out_st_r <= res_st_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data_m = out_dm_r;
  assign out_data_n = out_dn_r;
  assign out_link_m = out_lm_r;
  assign out_link_n = out_ln_r;
  assign out_status = out_st_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DWAIT || state_r == S_LWAIT))
    else $error("divider finished outside a wait state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("request accepted while previous one still in work");

  a_ok_n_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> (out_data_n != '0 && out_link_n != '0))
    else $error("good result with zero N");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_data_m == '0 && out_data_n == '0 && out_link_m == '0 && out_link_n == '0))
    else $error("error result with nonzero fields");

endmodule
